FILE: sv/mirp_pkg.sv
// shared types and codes for the message index record parser
// no dependencies
package mirp_pkg;

  localparam int TableEntries = 16;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);

  // item functions
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_BYTE  = 2'd2;
  localparam logic [1:0] FUNC_END   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_REF    = 2'd0;
  localparam logic [1:0] KIND_TOTAL  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TRUNC      = 3'd1;
  localparam logic [2:0] ST_UNEXPECTED = 3'd2;
  localparam logic [2:0] ST_SHORT      = 3'd3;
  localparam logic [2:0] ST_MISMATCH   = 3'd4;
  localparam logic [2:0] ST_BADARRAY   = 3'd5;
  localparam logic [2:0] ST_MISSING    = 3'd6;

  // parse phases
  localparam logic [2:0] PH_OPCODE = 3'd0;
  localparam logic [2:0] PH_LENGTH = 3'd1;
  localparam logic [2:0] PH_CHAN   = 3'd2;
  localparam logic [2:0] PH_ARRAY  = 3'd3;
  localparam logic [2:0] PH_ENTRY  = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;

  localparam logic [7:0]  OPCODE_MSG_INDEX = 8'h07;
  localparam logic [31:0] PREFIX_BYTES     = 32'd9;
  localparam logic [63:0] HEADER_BYTES     = 64'd6;
  localparam logic [63:0] RECORD_OVERHEAD  = 64'd15;
  localparam logic [31:0] ENTRY_BYTES      = 32'd16;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] chan;
    logic [63:0] file_offset;
    logic [31:0] region_bytes;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_channel;
    logic [63:0] amount;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic load;
    logic parse;
    logic dump_init;
    logic dump_step;
    logic dump_emit;
    logic status_emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_valid;
    logic dump_done;
    logic dump_hit;
  } stat_t;

endpackage

FILE: sv/mirp_ctrl.sv
// controller: item acceptance, end-of-region dump sequencing
// depends on mirp_pkg
module mirp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [1:0]       item_func,
  input  logic             result_stall,
  input  mirp_pkg::stat_t  stat,
  output logic             item_stall,
  output mirp_pkg::cmd_t   cmd
);
  import mirp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DUMP  = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       take;

  assign out_free   = !stat.out_valid || !result_stall;
  assign item_stall = (state != S_IDLE) || !out_free;
  assign take       = item_valid && !item_stall;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (item_func)
            FUNC_START: cmd.start = 1'b1;
            FUNC_LOAD:  cmd.load  = 1'b1;
            FUNC_BYTE:  cmd.parse = 1'b1;
            FUNC_END: begin
              cmd.dump_init = 1'b1;
              state_next    = S_DUMP;
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (stat.dump_done) begin
          state_next = S_FINAL;
        end else if (!stat.dump_hit) begin
          cmd.dump_step = 1'b1;
        end else if (out_free) begin
          cmd.dump_step = 1'b1;
          cmd.dump_emit = 1'b1;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          cmd.status_emit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/mirp_dp.sv
// datapath: expected table, byte parser, totals and result register
// depends on mirp_pkg
module mirp_dp (
  input  logic              clk,
  input  logic              rst,
  input  mirp_pkg::item_t   item,
  input  mirp_pkg::cmd_t    cmd,
  input  logic              result_stall,
  output mirp_pkg::stat_t   stat,
  output logic              result_valid,
  output mirp_pkg::result_t result
);
  import mirp_pkg::*;

  // table storage
  logic [15:0]             exp_chan [TableEntries];
  logic [63:0]             exp_off  [TableEntries];
  logic [63:0]             total    [TableEntries];
  logic [TableEntries-1:0] seen;
  logic [CntW-1:0]         count;

  // region and parse state
  logic [63:0] region_base;
  logic [31:0] region_len;
  logic [31:0] byte_pos;
  logic [2:0]  phase;
  logic [63:0] accum;
  logic [3:0]  fcount;
  logic [63:0] body;
  logic [63:0] rec_start;
  logic [IdxW-1:0] match_slot;
  logic [15:0] match_chan;
  logic [31:0] arr_rem;
  logic [2:0]  err;

  // dump state
  logic [CntW-1:0] dump_idx;
  logic [CntW-1:0] seen_cnt;

  // next values
  logic [2:0]  phase_next;
  logic [63:0] accum_next;
  logic [3:0]  fcount_next;
  logic [63:0] body_next;
  logic [63:0] rec_start_next;
  logic [IdxW-1:0] match_slot_next;
  logic [15:0] match_chan_next;
  logic [31:0] arr_rem_next;
  logic [2:0]  err_next;
  logic        tot_wr;
  logic        emit_ref;

  logic [7:0]  b;
  logic        active;
  logic [63:0] acc_b;
  logic [63:0] body_dec;
  logic [15:0] key;
  logic [TableEntries-1:0] hit_vec;
  logic        hit_any;
  logic [IdxW-1:0] hit_idx;
  logic [IdxW-1:0] rd_idx;
  logic [63:0] rd_total;
  logic [31:0] left;
  logic [31:0] arr;
  logic [2:0]  final_st;

  assign b        = item.data_byte;
  assign active   = (err == ST_OK) && (byte_pos < region_len);
  assign acc_b    = accum | (64'(b) << {fcount[2:0], 3'b000});
  assign body_dec = body - 64'd1;
  assign left     = region_len - byte_pos - 32'd1;
  assign arr      = acc_b[31:0];

  // channel lookup over the filled part of the table, lowest slot wins
  assign key = cmd.load ? item.chan : {b, accum[7:0]};
  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hit_vec[i] = (CntW'(i) < count) && (exp_chan[i] == key);
    end
    hit_any = |hit_vec;
    hit_idx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = IdxW'(i);
    end
  end

  // shared read port for totals and seen bits
  assign rd_idx   = cmd.parse ? match_slot : dump_idx[IdxW-1:0];
  assign rd_total = seen[rd_idx] ? total[rd_idx] : 64'd0;

  assign stat.out_valid = result_valid;
  assign stat.dump_done = dump_idx >= count;
  assign stat.dump_hit  = seen[dump_idx[IdxW-1:0]];

  // per-byte parse step
  always_comb begin
    phase_next      = phase;
    accum_next      = accum;
    fcount_next     = fcount;
    body_next       = body;
    rec_start_next  = rec_start;
    match_slot_next = match_slot;
    match_chan_next = match_chan;
    arr_rem_next    = arr_rem;
    err_next        = err;
    tot_wr          = 1'b0;
    emit_ref        = 1'b0;
    unique case (phase)
      PH_OPCODE: begin
        if ((region_len - byte_pos) < PREFIX_BYTES) begin
          err_next = ST_TRUNC;
        end else if (b != OPCODE_MSG_INDEX) begin
          err_next = ST_UNEXPECTED;
        end else begin
          rec_start_next = region_base + 64'(byte_pos);
          accum_next     = '0;
          fcount_next    = '0;
          phase_next     = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        accum_next  = acc_b;
        fcount_next = fcount + 4'd1;
        if (fcount == 4'd7) begin
          if (acc_b > 64'(left)) begin
            err_next = ST_UNEXPECTED;
          end else if (acc_b < HEADER_BYTES) begin
            err_next = ST_SHORT;
          end else begin
            body_next   = acc_b;
            accum_next  = '0;
            fcount_next = '0;
            phase_next  = PH_CHAN;
          end
        end
      end
      PH_CHAN: begin
        accum_next  = acc_b;
        fcount_next = fcount + 4'd1;
        body_next   = body_dec;
        if (fcount == 4'd1) begin
          if (hit_any) match_slot_next = hit_idx;
          if (!hit_any || exp_off[hit_idx] != rec_start) begin
            err_next = ST_MISMATCH;
          end else begin
            match_chan_next = key;
            accum_next      = '0;
            fcount_next     = '0;
            phase_next      = PH_ARRAY;
          end
        end
      end
      PH_ARRAY: begin
        accum_next  = acc_b;
        fcount_next = fcount + 4'd1;
        body_next   = body_dec;
        if (fcount == 4'd3) begin
          if (arr[3:0] != 4'd0 || 64'(arr) > body_dec) begin
            err_next = ST_BADARRAY;
          end else begin
            tot_wr       = 1'b1;
            arr_rem_next = arr;
            body_next    = body_dec - 64'(arr);
            accum_next   = '0;
            fcount_next  = '0;
            if (arr != 32'd0) phase_next = PH_ENTRY;
            else if (body_dec != 64'(arr)) phase_next = PH_SKIP;
            else phase_next = PH_OPCODE;
          end
        end
      end
      PH_ENTRY: begin
        if (fcount[3]) accum_next = acc_b;
        fcount_next = fcount + 4'd1;
        if (fcount == 4'd15) begin
          emit_ref     = 1'b1;
          arr_rem_next = arr_rem - ENTRY_BYTES;
          accum_next   = '0;
          fcount_next  = '0;
          if (arr_rem != ENTRY_BYTES) phase_next = PH_ENTRY;
          else if (body != 64'd0) phase_next = PH_SKIP;
          else phase_next = PH_OPCODE;
        end
      end
      default: begin
        body_next = body_dec;
        if (body_dec == 64'd0) phase_next = PH_OPCODE;
      end
    endcase
  end

  // final status of the region
  always_comb begin
    priority if (err != ST_OK) final_st = err;
    else if (byte_pos < region_len) final_st = ST_TRUNC;
    else if (seen_cnt != count) final_st = ST_MISSING;
    else final_st = ST_OK;
  end

  // control state: counts, seen bits, error, phase
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      seen        <= '0;
      region_base <= '0;
      region_len  <= '0;
      byte_pos    <= '0;
      phase       <= PH_OPCODE;
      fcount      <= '0;
      err         <= ST_OK;
      match_slot  <= '0;
      dump_idx    <= '0;
      seen_cnt    <= '0;
    end else begin
      if (cmd.start) begin
        region_base <= item.file_offset;
        region_len  <= item.region_bytes;
        count       <= '0;
        seen        <= '0;
        byte_pos    <= '0;
        phase       <= PH_OPCODE;
        fcount      <= '0;
        err         <= ST_OK;
        match_slot  <= '0;
      end
      if (cmd.load && !hit_any && count < CntW'(TableEntries)) begin
        seen[count[IdxW-1:0]] <= 1'b0;
        count                 <= count + CntW'(1);
      end
      if (cmd.parse && active) begin
        phase      <= phase_next;
        fcount     <= fcount_next;
        err        <= err_next;
        match_slot <= match_slot_next;
        byte_pos   <= byte_pos + 32'd1;
        if (tot_wr) seen[match_slot] <= 1'b1;
      end
      if (cmd.dump_init) begin
        dump_idx <= '0;
        seen_cnt <= '0;
      end
      if (cmd.dump_step) begin
        dump_idx <= dump_idx + CntW'(1);
        if (cmd.dump_emit) seen_cnt <= seen_cnt + CntW'(1);
      end
    end
  end

  // payload registers: table, totals, parse fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (hit_any) begin
        exp_off[hit_idx] <= item.file_offset;
      end else if (count < CntW'(TableEntries)) begin
        exp_chan[count[IdxW-1:0]] <= item.chan;
        exp_off[count[IdxW-1:0]]  <= item.file_offset;
      end
    end
    if (cmd.start) begin
      accum     <= '0;
      body      <= '0;
      rec_start <= '0;
      arr_rem   <= '0;
    end else if (cmd.parse && active) begin
      accum      <= accum_next;
      body       <= body_next;
      rec_start  <= rec_start_next;
      arr_rem    <= arr_rem_next;
      match_chan <= match_chan_next;
      if (tot_wr) total[match_slot] <= rd_total + RECORD_OVERHEAD + body_dec;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((cmd.parse && active && emit_ref) || cmd.dump_emit || cmd.status_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.parse && active && emit_ref) begin
      result <= '{kind: KIND_REF, out_channel: match_chan, amount: acc_b,
                  status: ST_OK, last: 1'b0};
    end else if (cmd.dump_emit) begin
      result <= '{kind: KIND_TOTAL, out_channel: exp_chan[dump_idx[IdxW-1:0]],
                  amount: rd_total, status: ST_OK, last: 1'b0};
    end else if (cmd.status_emit) begin
      result <= '{kind: KIND_STATUS, out_channel: 16'd0, amount: 64'd0,
                  status: final_st, last: 1'b1};
    end
  end

endmodule

FILE: sv/message_index_record_parser_core.sv
// Message index record parser, top level.
// Items arrive on the item channel (item_valid / item_stall / item), results
// leave on the result channel (result_valid / result_stall / result).
// A start item sets the region base and length and empties the table; load
// items add expected (channel, record offset) pairs, up to 16 entries.
// Byte items are parsed one per cycle while the result register is free; the
// sixteenth byte of each array entry puts a message reference into the result
// register, visible the next cycle. An end item starts the sequencer, which
// walks the table one slot a cycle, holding on a seen slot while the result
// register is busy, emitting one total for each channel that was seen, then
// a status result with last set. Start, load and byte items leave the
// controller idle, so the sustained rate is one item per cycle while the
// result register is free. Items are taken only while the controller is
// idle and the result register is empty or being taken; a stalled result
// holds, and the item channel stalls behind it. Reset empties the table,
// clears the parse state and the result register; no clearing pass is needed.
module message_index_record_parser_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  mirp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output mirp_pkg::result_t result
);
  import mirp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mirp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_func    (item.func),
    .result_stall (result_stall),
    .stat         (stat),
    .item_stall   (item_stall),
    .cmd          (cmd)
  );

  mirp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .result_stall (result_stall),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

FILE: sv/mirp_checker.sv
// port-level checks for the message index record parser
// depends on mirp_pkg and message_index_record_parser_core
module mirp_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input mirp_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input mirp_pkg::result_t result
);
  import mirp_pkg::*;

  // the last flag marks exactly the status result
  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last == (result.kind == KIND_STATUS)))
    else $error("last flag and status kind disagree");

  // an end transfer starts the dump, so no item is taken next cycle
  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.func == FUNC_END) |=> item_stall)
    else $error("item taken right after end of region");

  // results other than status carry ok
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind != KIND_STATUS) |-> (result.status == ST_OK))
    else $error("nonzero status on reference or total");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind message_index_record_parser_core mirp_checker u_mirp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
